FILE: rtl/core/pdasc_pkg.sv
// ----------------------------------------------------------------------------
// pdasc_pkg: shared types and constants
// Field structs, character codes and the decoded item record for the
// packed decimal to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pdasc_pkg;

    // Digit capacity: limited by the configured maximum and by what 64 bits hold
    localparam int MAX_DIGITS = 15;
    localparam int HW_DIGITS  = 15;
    localparam int NUM_DIGITS = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;

    localparam logic [3:0] SIGN_NEG   = 4'hD;
    localparam logic [6:0] DIGIT_BASE = 7'h30;
    localparam logic [6:0] CHAR_POINT = 7'h2E;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic [63:0] packed_value;
        logic [3:0]  digit_count;
        logic [3:0]  scale;
    } in_t;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_char;
    } out_t;

    // Decoded request, ready for serial emission
    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] digits;   // digit nibbles, index 0 least significant
        logic                       neg;
        logic                       has_int;  // at least one integer digit position
        logic [3:0]                 first;    // top integer digit to print
        logic [3:0]                 scale;    // clamped scale
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/packed_decimal_to_ascii_top.sv
// ----------------------------------------------------------------------------
// packed_decimal_to_ascii_top: packed decimal field to ASCII text
// Converts one packed decimal field per request into a stream of characters.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one request: the packed
//   bytes right aligned in 64 bits (low nibble is the sign), the digit count
//   and the scale. Output channel (out_valid/out_ready/out_data) returns the
//   text one character per transfer, with last_char set on the final one.
//   A request yields 1 to 18 characters: optional '-', integer digits with
//   leading zeros dropped (at least one kept), then '.' and the fraction.
//   The request is first registered in the sequencer, which then writes its
//   characters into the output register. Throughput: one character per cycle
//   while the receiver takes them; the single character sequencer sets this.
//   The next request is taken in the cycle its predecessor's last character
//   moves to the output register, so streams run back to back with no gap.
//   When the receiver stalls, the output register holds and the sequencer
//   waits; in_ready stays low until the last character can advance.
//   Reset empties the sequencer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_decimal_to_ascii_top
    import pdasc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire in_t   in_data,
    output logic       out_valid,
    input  wire        out_ready,
    output out_t       out_data
);

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_INT,
        PH_POINT,
        PH_FRAC
    } phase_t;

    item_t  prep_item;

    logic   busy_reg,      busy_next;
    phase_t phase_reg,     phase_next;
    logic [3:0] idx_reg,   idx_next;
    item_t  item_reg,      item_next;
    logic   out_valid_reg, out_valid_next;
    out_t   out_reg,       out_next;

    logic       step;
    logic       accept;
    logic       end_int;
    logic [3:0] nib;
    logic [6:0] ch;
    logic       ch_last;
    phase_t     ph_adv;
    logic [3:0] idx_adv;

    pdasc_prep u_prep (
        .req  (in_data),
        .item (prep_item)
    );

    // Character generator for the current cursor
    always_comb
    begin
        nib     = item_reg.digits[idx_reg];
        end_int = !item_reg.has_int || (idx_reg == item_reg.scale);
        ch      = CHAR_MINUS;
        ch_last = 1'b0;
        ph_adv  = phase_reg;
        idx_adv = idx_reg;

        unique case (phase_reg)
            PH_SIGN:
            begin
                ch      = CHAR_MINUS;
                ph_adv  = PH_INT;
                idx_adv = item_reg.first;
            end
            PH_INT:
            begin
                ch      = item_reg.has_int ? (DIGIT_BASE + {3'b000, nib}) : DIGIT_BASE;
                ch_last = end_int && (item_reg.scale == 4'd0);
                if (end_int)
                begin
                    ph_adv = PH_POINT;
                end
                else
                begin
                    idx_adv = idx_reg - 4'd1;
                end
            end
            PH_POINT:
            begin
                ch      = CHAR_POINT;
                ph_adv  = PH_FRAC;
                idx_adv = item_reg.scale - 4'd1;
            end
            PH_FRAC:
            begin
                ch      = DIGIT_BASE + {3'b000, nib};
                ch_last = (idx_reg == 4'd0);
                idx_adv = idx_reg - 4'd1;
            end
            default:
            begin
                ch = CHAR_MINUS;
            end
        endcase
    end

    // Handshake and next state
    always_comb
    begin
        step     = busy_reg && (!out_valid_reg || out_ready);
        in_ready = !busy_reg || (step && ch_last);
        accept   = in_valid && in_ready;

        busy_next      = busy_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (step)
        begin
            phase_next = ph_adv;
            idx_next   = idx_adv;
            if (ch_last)
            begin
                busy_next = 1'b0;
            end
        end

        // Load a new request over the finished one
        if (accept)
        begin
            busy_next  = 1'b1;
            item_next  = prep_item;
            phase_next = prep_item.neg ? PH_SIGN : PH_INT;
            idx_next   = prep_item.first;
        end

        if (step)
        begin
            out_valid_next      = 1'b1;
            out_next.ascii_char = ch;
            out_next.last_char  = ch_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_INT;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            item_reg      <= item_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pdasc_prep.sv
// ----------------------------------------------------------------------------
// pdasc_prep: request decode
// Clamps digit count and scale, extracts the sign and locates the first
// significant integer digit.
// ----------------------------------------------------------------------------
`default_nettype none

module pdasc_prep
    import pdasc_pkg::*;
(
    input  wire in_t   req,
    output item_t      item
);

    logic [3:0] n;
    logic [3:0] s;

    always_comb
    begin
        if ({1'b0, req.digit_count} > 5'(NUM_DIGITS))
        begin
            n = 4'(NUM_DIGITS);
        end
        else
        begin
            n = req.digit_count;
        end

        if (req.scale > n)
        begin
            s = n;
        end
        else
        begin
            s = req.scale;
        end

        item.digits  = req.packed_value[4 +: 4*NUM_DIGITS];
        item.neg     = (req.packed_value[3:0] == SIGN_NEG);
        item.has_int = (n != s);
        item.scale   = s;

        // Highest non-zero integer digit wins; keep the lowest one otherwise
        item.first = s;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if ((4'(i) < n) && (4'(i) >= s) &&
                (req.packed_value[4*i + 4 +: 4] != 4'h0))
            begin
                item.first = 4'(i);
            end
        end
    end

endmodule

`default_nettype wire
